>>> design/sdvl_pkg.sv
`timescale 1ns / 1ps

package sdvl_pkg;

  // heading resolution, pi equals 2**(ANGLE_BITS-1)
  localparam int ANGLE_BITS = 16;

  // horner cells of the quarter-wave sine polynomial
  localparam int N_CELLS = 5;
  localparam int P_W     = 31;
  localparam int U_W     = 17;

  typedef logic [P_W-1:0] poly_t;

  // q30 coefficients, highest order first; the first cell sees p = 0
  localparam poly_t HORNER_COEF [N_CELLS] = '{
    31'd172272,
    31'd5026998,
    31'd85569306,
    31'd693598668,
    31'd1686629713
  };

  typedef enum logic [1:0] {
    REG_TARGET_RANGE = 2'd0,
    REG_TOLERANCE    = 2'd1,
    REG_APPR_SPEED   = 2'd2,
    REG_LAW_MODE     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [11:0] v;
    logic signed [9:0]  vd;
    logic               hold;
    logic               arr;
  } law_t;

  typedef struct packed {
    law_t        law;
    logic [15:0] ph;
  } head_t;

  typedef struct packed {
    poly_t          p;
    logic [U_W-1:0] u;
    logic [U_W-1:0] t;
    logic           neg;
  } lane_t;

  typedef struct packed {
    law_t  law;
    lane_t cos_l;
    lane_t sin_l;
  } cell_data_t;

endpackage

>>> design/sdvl_ifs.sv
`timescale 1ns / 1ps

interface sdvl_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        front_range_mm;
  logic signed [15:0] heading_angle;
  logic signed [15:0] altitude_down_mm;
  logic               sensors_ready;

  modport source (
    output valid, front_range_mm, heading_angle, altitude_down_mm, sensors_ready,
    input  ready
  );
  modport sink (
    input  valid, front_range_mm, heading_angle, altitude_down_mm, sensors_ready,
    output ready
  );
endinterface

interface sdvl_out_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] vel_north_mm_s;
  logic signed [11:0] vel_east_mm_s;
  logic signed [9:0]  vel_down_mm_s;
  logic               hold_position;
  logic               arrived;

  modport source (
    output valid, vel_north_mm_s, vel_east_mm_s, vel_down_mm_s, hold_position, arrived,
    input  ready
  );
  modport sink (
    input  valid, vel_north_mm_s, vel_east_mm_s, vel_down_mm_s, hold_position, arrived,
    output ready
  );
endinterface

>>> design/sdvl_law.sv
`timescale 1ns / 1ps

module sdvl_law (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [15:0]         front_range_mm,
  input  logic signed [15:0]  heading_angle,
  input  logic signed [15:0]  altitude_down_mm,
  input  logic                sensors_ready,
  input  logic [15:0]         target_range,
  input  logic [15:0]         tolerance,
  input  logic [10:0]         appr_speed,
  input  logic                law_mode,
  output logic                out_vld,
  output sdvl_pkg::head_t     out_d
);

  localparam int AW = sdvl_pkg::ANGLE_BITS;
  // 3277 / 65536 is exact for division by 20 below 1600
  localparam logic [11:0] RECIP_20   = 12'd3277;
  localparam logic [15:0] ARRIVE_ERR = 16'd300;
  localparam logic [15:0] SAT_ERR_20 = 16'd1600;
  localparam logic [14:0] FINE_LIM   = 15'd50;
  localparam logic [6:0]  SMOOTH_LIM = 7'd80;
  localparam logic [14:0] DOWN_LIM   = 15'd500;

  logic               vld_r;
  sdvl_pkg::head_t    d_r;
  sdvl_pkg::head_t    d_nxt;

  logic signed [16:0] e;
  logic [15:0]        ae;
  logic [22:0]        q20_prod;
  logic [10:0]        vmag;
  logic               vneg;
  logic signed [17:0] dz;
  logic [15:0]        dmag;
  logic [14:0]        dhalf;
  logic [8:0]         vd_mag;
  logic [AW-1:0]      ua;
  logic [15:0]        ph;

  assign ua = AW'(heading_angle);

  generate
    if (AW >= 16) begin : g_wide
      assign ph = ua[AW-1 -: 16];
    end else begin : g_narrow
      assign ph = {ua, {(16-AW){1'b0}}};
    end
  endgenerate

  always_comb begin
    e        = $signed({1'b0, front_range_mm}) - $signed({1'b0, target_range});
    ae       = e[16] ? 16'(-e) : e[15:0];
    q20_prod = 23'(ae[10:0]) * 23'(RECIP_20);

    // altitude hold toward -1000 mm at half gain
    dz     = -18'sd1000 - 18'(altitude_down_mm);
    dmag   = dz[17] ? 16'(-dz) : dz[15:0];
    dhalf  = dmag[15:1];
    vd_mag = (dhalf > DOWN_LIM) ? 9'(DOWN_LIM) : dhalf[8:0];

    vmag         = '0;
    vneg         = 1'b0;
    d_nxt.law.vd = '0;
    d_nxt.law.hold = 1'b0;
    d_nxt.law.arr  = 1'b0;

    priority if (!sensors_ready) begin
      d_nxt.law.hold = 1'b1;
    end else if (!law_mode) begin
      if (ae < tolerance) begin
        vmag = (ae[15:1] > FINE_LIM) ? 11'(FINE_LIM) : 11'(ae[15:1]);
        vneg = e[16];
      end else begin
        // with zero tolerance, zero error falls outside the band and backs off
        vmag = appr_speed;
        vneg = e[16] || (e == '0);
      end
      d_nxt.law.vd = dz[17] ? -10'(vd_mag) : 10'(vd_mag);
    end else if (ae < ARRIVE_ERR) begin
      d_nxt.law.hold = 1'b1;
      d_nxt.law.arr  = 1'b1;
    end else begin
      vmag = (ae >= SAT_ERR_20) ? 11'(SMOOTH_LIM) : 11'(q20_prod[22:16]);
      vneg = e[16];
    end

    d_nxt.law.v = vneg ? -12'(vmag) : 12'(vmag);
    d_nxt.ph    = ph;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

>>> design/sdvl_cell.sv
`timescale 1ns / 1ps

module sdvl_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  sdvl_pkg::cell_data_t in_d,
  input  sdvl_pkg::poly_t      coef,
  output logic                 out_vld,
  output sdvl_pkg::cell_data_t out_d
);

  logic                 vld_r;
  sdvl_pkg::cell_data_t d_r;
  sdvl_pkg::cell_data_t d_nxt;

  // one horner step: coef - (p * u) >> 16
  function automatic sdvl_pkg::poly_t horner_step(
    sdvl_pkg::poly_t             p,
    logic [sdvl_pkg::U_W-1:0]    u,
    sdvl_pkg::poly_t             c
  );
    logic [47:0] prod;
    prod = 48'(p) * 48'(u);
    return c - prod[46:16];
  endfunction

  always_comb begin
    d_nxt         = in_d;
    d_nxt.cos_l.p = horner_step(in_d.cos_l.p, in_d.cos_l.u, coef);
    d_nxt.sin_l.p = horner_step(in_d.sin_l.p, in_d.sin_l.u, coef);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

>>> design/standoff_distance_velocity_law_unit.sv
`timescale 1ns / 1ps

// an accepted input word passes the law, prep, horner cell, sine finish, multiply and output registers
// throughput: one word per cycle while out_ch.ready holds; the chain of horner cells is fully pipelined
// a stall reaches in_ch.ready in the same cycle through the stage enables, and
// bubbles are squeezed out under backpressure
// reset: synchronous, active low; registers return to 2000 / 300 / 300 / mode 0
// and every stage valid bit clears; no clearing pass is needed
module standoff_distance_velocity_law_unit (
  input  logic        clk,
  input  logic        rst_n,
  sdvl_in_if.sink     in_ch,
  sdvl_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NC      = sdvl_pkg::N_CELLS;
  // stage order: law, prep, cells, sine finish, rotate multiply, output
  localparam int ST_LAW  = 0;
  localparam int ST_PREP = 1;
  localparam int ST_CELL = 2;
  localparam int ST_FIN  = NC + 2;
  localparam int ST_MUL  = NC + 3;
  localparam int ST_OUT  = NC + 4;
  localparam int NSTG    = NC + 5;

  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam logic [15:0] Q15_MAX      = 16'd32767;
  localparam logic [13:0] VEL_MAX      = 14'd2047;
  localparam logic [13:0] VEL_MIN_MAG  = 14'd2048;

  // ---------------------------------------------------------------------------
  // configuration registers; write them only while the pipe is idle (not enforced here)
  // ---------------------------------------------------------------------------
  logic [15:0] target_r;
  logic [15:0] tol_r;
  logic [10:0] appr_r;
  logic        mode_r;
  logic        cfg_wr;
  sdvl_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  // low address bits are ignored, registers sit on word boundaries
  assign cfg_idx = sdvl_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= 16'd2000;
      tol_r    <= 16'd300;
      appr_r   <= 11'd300;
      mode_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sdvl_pkg::REG_TARGET_RANGE: target_r <= pwdata[15:0];
        sdvl_pkg::REG_TOLERANCE:    tol_r    <= pwdata[15:0];
        sdvl_pkg::REG_APPR_SPEED:   appr_r   <= pwdata[10:0];
        sdvl_pkg::REG_LAW_MODE:     mode_r   <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      sdvl_pkg::REG_TARGET_RANGE: prdata = {16'b0, target_r};
      sdvl_pkg::REG_TOLERANCE:    prdata = {16'b0, tol_r};
      sdvl_pkg::REG_APPR_SPEED:   prdata = {21'b0, appr_r};
      sdvl_pkg::REG_LAW_MODE:     prdata = {31'b0, mode_r};
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control: a stage loads when it is empty or its successor moves
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] stg_vld;
  logic [NSTG-1:0] stg_en;

  logic                  law_vld;
  sdvl_pkg::head_t       law_d;
  logic                  prep_vld_r;
  sdvl_pkg::cell_data_t  prep_r;
  logic [NC-1:0]         cell_vld;
  sdvl_pkg::cell_data_t  cell_d [NC];
  logic                  fin_vld_r;
  sdvl_pkg::law_t        fin_law_r;
  logic signed [16:0]    fin_cos_r;
  logic signed [16:0]    fin_sin_r;
  logic                  mul_vld_r;
  sdvl_pkg::law_t        mul_law_r;
  logic signed [28:0]    mul_n_r;
  logic signed [28:0]    mul_e_r;
  logic                  out_vld_r;

  always_comb begin
    stg_vld[ST_LAW]  = law_vld;
    stg_vld[ST_PREP] = prep_vld_r;
    for (int i = 0; i < NC; i++) begin
      stg_vld[ST_CELL + i] = cell_vld[i];
    end
    stg_vld[ST_FIN] = fin_vld_r;
    stg_vld[ST_MUL] = mul_vld_r;
    stg_vld[ST_OUT] = out_vld_r;

    stg_en[ST_OUT] = !stg_vld[ST_OUT] || out_ch.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      stg_en[i] = !stg_vld[i] || stg_en[i+1];
    end
  end

  assign in_ch.ready = stg_en[ST_LAW];

  // ---------------------------------------------------------------------------
  // stage 0: control law, body speed, vertical speed, hold flags and phase
  // ---------------------------------------------------------------------------
  sdvl_law u_law (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (stg_en[ST_LAW]),
    .in_vld           (in_ch.valid),
    .front_range_mm   (in_ch.front_range_mm),
    .heading_angle    (in_ch.heading_angle),
    .altitude_down_mm (in_ch.altitude_down_mm),
    .sensors_ready    (in_ch.sensors_ready),
    .target_range     (target_r),
    .tolerance        (tol_r),
    .appr_speed       (appr_r),
    .law_mode         (mode_r),
    .out_vld          (law_vld),
    .out_d            (law_d)
  );

  // ---------------------------------------------------------------------------
  // stage 1: fold the phase into a quarter wave, t = 4x and u = t*t >> 16
  // cosine lane runs a quarter turn ahead of the sine lane
  // ---------------------------------------------------------------------------
  function automatic sdvl_pkg::lane_t prep_lane(logic [15:0] ph);
    logic [14:0]     xx;
    logic [16:0]     t;
    logic [33:0]     sq;
    sdvl_pkg::lane_t l;
    xx    = ph[14] ? (15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
    t     = {xx, 2'b00};
    sq    = 34'(t) * 34'(t);
    l.p   = '0;
    l.u   = sq[32:16];
    l.t   = t;
    l.neg = ph[15];
    return l;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else if (stg_en[ST_PREP]) begin
      prep_vld_r <= law_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_PREP]) begin
      prep_r.law   <= law_d.law;
      prep_r.cos_l <= prep_lane(law_d.ph + QUARTER_TURN);
      prep_r.sin_l <= prep_lane(law_d.ph);
    end
  end

  // ---------------------------------------------------------------------------
  // horner chain: each cell applies one coefficient to both lanes
  // ---------------------------------------------------------------------------
  genvar gi;
  generate
    for (gi = 0; gi < NC; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        sdvl_cell u_cell (
          .clk     (clk),
          .rst_n   (rst_n),
          .en      (stg_en[ST_CELL + gi]),
          .in_vld  (prep_vld_r),
          .in_d    (prep_r),
          .coef    (sdvl_pkg::HORNER_COEF[gi]),
          .out_vld (cell_vld[gi]),
          .out_d   (cell_d[gi])
        );
      end else begin : g_next
        sdvl_cell u_cell (
          .clk     (clk),
          .rst_n   (rst_n),
          .en      (stg_en[ST_CELL + gi]),
          .in_vld  (cell_vld[gi-1]),
          .in_d    (cell_d[gi-1]),
          .coef    (sdvl_pkg::HORNER_COEF[gi]),
          .out_vld (cell_vld[gi]),
          .out_d   (cell_d[gi])
        );
      end
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // sine finish: (p * t) >> 16, round to q1.15, cap, apply half-turn sign
  // ---------------------------------------------------------------------------
  function automatic logic signed [16:0] lane_sine(sdvl_pkg::lane_t l);
    logic [47:0] prod;
    logic [32:0] rr;
    logic [15:0] mag;
    prod = 48'(l.p) * 48'(l.t);
    rr   = 33'(prod[47:16]) + 33'd16384;
    mag  = (rr[32:15] > 18'(Q15_MAX)) ? Q15_MAX : rr[30:15];
    return l.neg ? -17'(mag) : 17'(mag);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (stg_en[ST_FIN]) begin
      fin_vld_r <= cell_vld[NC-1];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_FIN]) begin
      fin_law_r <= cell_d[NC-1].law;
      fin_cos_r <= lane_sine(cell_d[NC-1].cos_l);
      fin_sin_r <= lane_sine(cell_d[NC-1].sin_l);
    end
  end

  // ---------------------------------------------------------------------------
  // rotation multiply: body speed times cosine and sine
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else if (stg_en[ST_MUL]) begin
      mul_vld_r <= fin_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_MUL]) begin
      mul_law_r <= fin_law_r;
      mul_n_r   <= 29'($signed(fin_law_r.v)) * 29'(fin_cos_r);
      mul_e_r   <= 29'($signed(fin_law_r.v)) * 29'(fin_sin_r);
    end
  end

  // ---------------------------------------------------------------------------
  // output register: q15 scale toward zero and saturate to 12 bits
  // ---------------------------------------------------------------------------
  function automatic logic signed [11:0] scale_q15(logic signed [28:0] prod);
    logic [28:0] mag;
    logic [13:0] r;
    logic        neg;
    neg = prod[28];
    mag = neg ? 29'(-prod) : 29'(prod);
    r   = mag[28:15];
    if (neg) begin
      return (r > VEL_MIN_MAG) ? -12'(VEL_MIN_MAG) : -12'(r);
    end
    return (r > VEL_MAX) ? 12'(VEL_MAX) : 12'(r);
  endfunction

  logic signed [11:0] vn_r;
  logic signed [11:0] ve_r;
  logic signed [9:0]  vd_r;
  logic               hold_r;
  logic               arr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (stg_en[ST_OUT]) begin
      out_vld_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_OUT]) begin
      vn_r   <= scale_q15(mul_n_r);
      ve_r   <= scale_q15(mul_e_r);
      vd_r   <= mul_law_r.vd;
      hold_r <= mul_law_r.hold;
      arr_r  <= mul_law_r.arr;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.vel_north_mm_s = vn_r;
  assign out_ch.vel_east_mm_s  = ve_r;
  assign out_ch.vel_down_mm_s  = vd_r;
  assign out_ch.hold_position  = hold_r;
  assign out_ch.arrived        = arr_r;

endmodule
